// ----- hw/rtl/rlaq_pkg.sv -----
// ----------------------------------------------------------------------------
// rlaq_pkg
// Shared types and constants of the receive line assembler and line queue.
// ----------------------------------------------------------------------------
package rlaq_pkg;

  // Operation carried in the slave tuser field
  localparam int OP_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_RX      = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Slave tdata layout
  localparam int IN_TDATA_W   = 16;
  localparam int IN_BYTE_LSB  = 0;
  localparam int IN_INDEX_LSB = 8;

  // Master tdata layout, lowest bit first
  localparam int OUT_TDATA_W   = 56;
  localparam int OUT_RDATA_LSB = 0;
  localparam int OUT_HLEN_LSB  = 8;
  localparam int OUT_HLEN_W    = 9;
  localparam int OUT_WAIT_LSB  = 17;
  localparam int OUT_WAIT_W    = 4;
  localparam int OUT_COMMIT    = 21;
  localparam int OUT_DROP      = 22;
  localparam int OUT_DISCARD   = 23;
  localparam int OUT_OVL_LSB   = 24;

endpackage

// ----- hw/rtl/rlaq_ram.sv -----
// ----------------------------------------------------------------------------
// rlaq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rlaq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/rx_line_assembler_queue_core.sv -----
// ----------------------------------------------------------------------------
// rx_line_assembler_queue_core
// Assembles received bytes into LF-terminated lines and queues them in slots.
// ----------------------------------------------------------------------------
// Usage
//   Slave channel (s_*): one transfer is one command. tuser selects receive
//   byte, read byte of head line or release head line; tdata carries the
//   received byte and the read index. Master channel (m_*): exactly one
//   status transfer for each command, in command order.
//   A command is accepted in the idle state, which issues the reads of the
//   line store and the length store; the exec state then consumes the registered
//   read data, updates state and loads the output register. A new command is
//   taken only after the last one has executed, as the stores read registered.
//   Lines are assembled straight into the free slot after the queue tail, so
//   a finished line is queued by writing its length and advancing the tail;
//   no copy is made. The store holds QUEUE_LINES+1 slots for this.
//   Reset clears the control state at once; the byte and length stores need
//   no clearing pass, as they are only read where written.
//   While the receiver stalls, the result is held in the output register; one
//   further command may be accepted and then waits until the register frees.
// ----------------------------------------------------------------------------
module rx_line_assembler_queue_core #(
  parameter int LINE_BYTES  = 256,
  parameter int QUEUE_LINES = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // slave: rx_byte, read_index
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rlaq_pkg::IN_TDATA_W-1:0]    s_tdata,
  // slave: operation
  input  logic [rlaq_pkg::OP_W-1:0]          s_tuser,
  // master: read_data, head_length, lines_waiting, line_committed,
  //         line_dropped, discarding, overlong_lines
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [rlaq_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  import rlaq_pkg::*;

  localparam int NS = QUEUE_LINES + 1;            // physical slots
  localparam int SW = $clog2(NS);                 // slot index width
  localparam int IW = $clog2(LINE_BYTES);         // byte offset width
  localparam int LW = $clog2(LINE_BYTES + 1);     // line length width
  localparam int CW = $clog2(QUEUE_LINES + 1);    // queued count width
  localparam int LDEPTH = NS * (2 ** IW);

  // Sequencer
  state_t state, state_next;
  logic   accept;
  logic   exec_fire;

  // Registered command
  op_t        op_q;
  logic [7:0] byte_q;
  logic [7:0] idx_q;

  // Control state
  logic [LW-1:0] asm_len,  asm_len_next;
  logic          last_cr,  last_cr_next;
  logic          discard,  discard_next;
  logic [31:0]   overlong, overlong_next;
  logic [SW-1:0] head,     head_next;
  logic [SW-1:0] tail,     tail_next;
  logic [CW-1:0] count,    count_next;
  logic [LW-1:0] head_len, head_len_next;

  // Store ports
  logic             line_we;
  logic [SW+IW-1:0] line_waddr;
  logic [SW+IW-1:0] line_raddr;
  logic [7:0]       line_rdata;
  logic             len_we;
  logic [SW-1:0]    len_raddr;
  logic [LW-1:0]    len_rdata;

  // Step results
  logic [7:0]    rdata;
  logic          committed;
  logic          dropped;
  logic [LW-1:0] trim_len;
  logic [SW-1:0] head_inc;
  logic [SW-1:0] tail_inc;

  // --------------------------------------------------------------------------
  // Sequencer: idle -> exec, hold in exec while the output register is full
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    accept    = s_tvalid && (state == ST_IDLE);
    exec_fire = (state == ST_EXEC) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the command; payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_t'(s_tuser);
      byte_q <= s_tdata[IN_BYTE_LSB +: 8];
      idx_q  <= s_tdata[IN_INDEX_LSB +: 8];
    end
  end

  // --------------------------------------------------------------------------
  // Stores: issue reads on accept, write during execution
  // --------------------------------------------------------------------------
  assign head_inc = (head == SW'(NS - 1)) ? '0 : head + SW'(1);
  assign tail_inc = (tail == SW'(NS - 1)) ? '0 : tail + SW'(1);

  assign line_raddr = {head, IW'(s_tdata[IN_INDEX_LSB +: 8])};
  assign line_waddr = {tail, IW'(asm_len)};
  assign len_raddr  = head_inc;

  rlaq_ram #(
    .WIDTH (8),
    .DEPTH (LDEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (line_waddr),
    .wdata (byte_q),
    .re    (accept),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  rlaq_ram #(
    .WIDTH (LW),
    .DEPTH (NS)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (tail),
    .wdata (trim_len),
    .re    (accept),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  // --------------------------------------------------------------------------
  // Step: next state from the registered command and read data
  // --------------------------------------------------------------------------
  // Strip one trailing CR from the assembled line
  assign trim_len = asm_len - LW'(last_cr && (asm_len != '0));

  always_comb begin
    asm_len_next  = asm_len;
    last_cr_next  = last_cr;
    discard_next  = discard;
    overlong_next = overlong;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    head_len_next = head_len;
    rdata         = '0;
    committed     = 1'b0;
    dropped       = 1'b0;
    line_we       = 1'b0;
    len_we        = 1'b0;
    case (op_q)
      OP_RX: begin
        if (discard) begin
          // skip the overlong line up to and including its LF
          if (byte_q == CH_LF) begin
            discard_next = 1'b0;
            asm_len_next = '0;
          end
        end else if (byte_q == CH_LF) begin
          asm_len_next = '0;
          if (trim_len != '0) begin
            if (count == CW'(QUEUE_LINES)) begin
              dropped = 1'b1;
            end else begin
              committed  = 1'b1;
              len_we     = exec_fire;
              tail_next  = tail_inc;
              count_next = count + CW'(1);
              if (count == '0) begin
                head_len_next = trim_len;
              end
            end
          end
        end else if (asm_len == LW'(LINE_BYTES)) begin
          discard_next  = 1'b1;
          asm_len_next  = '0;
          overlong_next = overlong + 32'd1;
        end else begin
          line_we      = exec_fire;
          asm_len_next = asm_len + LW'(1);
          last_cr_next = (byte_q == CH_CR);
        end
      end
      OP_READ: begin
        if ((count != '0) && (32'(idx_q) < 32'(head_len))) begin
          rdata = line_rdata;
        end
      end
      OP_RELEASE: begin
        if (count != '0) begin
          head_next     = head_inc;
          count_next    = count - CW'(1);
          head_len_next = len_rdata;
        end
      end
      default: begin
        // unused code: report state, change nothing
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      asm_len  <= '0;
      last_cr  <= 1'b0;
      discard  <= 1'b0;
      overlong <= '0;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
      head_len <= '0;
    end else if (exec_fire) begin
      asm_len  <= asm_len_next;
      last_cr  <= last_cr_next;
      discard  <= discard_next;
      overlong <= overlong_next;
      head     <= head_next;
      tail     <= tail_next;
      count    <= count_next;
      head_len <= head_len_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: load on execution, drop valid once the transfer is taken
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      m_tdata[OUT_RDATA_LSB +: 8]          <= rdata;
      m_tdata[OUT_HLEN_LSB +: OUT_HLEN_W]  <= (count_next != '0) ?
                                              OUT_HLEN_W'(head_len_next) : '0;
      m_tdata[OUT_WAIT_LSB +: OUT_WAIT_W]  <= OUT_WAIT_W'(count_next);
      m_tdata[OUT_COMMIT]                  <= committed;
      m_tdata[OUT_DROP]                    <= dropped;
      m_tdata[OUT_DISCARD]                 <= discard_next;
      m_tdata[OUT_OVL_LSB +: 32]           <= overlong_next;
    end
  end

endmodule

// ----- hw/rtl/rlaq_checker.sv -----
// ----------------------------------------------------------------------------
// rlaq_checker
// Port-level checks of the line assembler queue, bound to the top level.
// ----------------------------------------------------------------------------
module rlaq_checker #(
  parameter int QUEUE_LINES = 8
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [rlaq_pkg::OUT_TDATA_W-1:0] m_tdata
);

  import rlaq_pkg::*;

  logic [OUT_WAIT_W-1:0] waiting;
  logic [OUT_HLEN_W-1:0] hlen;

  assign waiting = m_tdata[OUT_WAIT_LSB +: OUT_WAIT_W];
  assign hlen    = m_tdata[OUT_HLEN_LSB +: OUT_HLEN_W];

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A line is either queued or dropped, never both
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[OUT_COMMIT] && m_tdata[OUT_DROP]))
    else $error("line both committed and dropped");

  // Head length is non-zero exactly when lines wait
  a_hlen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((waiting == '0) == (hlen == '0)))
    else $error("head length disagrees with queue fill");

  // A drop leaves the queue full; a committed line, which leaves it non-empty, is not checked
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[OUT_DROP] |-> waiting == OUT_WAIT_W'(QUEUE_LINES))
    else $error("line dropped while queue not full");

endmodule

bind rx_line_assembler_queue_core rlaq_checker #(
  .QUEUE_LINES (QUEUE_LINES)
) u_rlaq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
